// ===== rtl/sha1s_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher package
// Shared item types, controller/datapath command and status structs, and the
// SHA-1 constants.
// ----------------------------------------------------------------------------
package sha1s_pkg;

    // One input request: a message byte and its flags.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    // One output request: a digest word, its index and the last-word flag.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Source of the byte shifted into the block window.
    localparam logic [1:0] PUSH_DATA = 2'd0;
    localparam logic [1:0] PUSH_PAD  = 2'd1;
    localparam logic [1:0] PUSH_ZERO = 2'd2;
    localparam logic [1:0] PUSH_LEN  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       push;       // shift one byte into the block window
        logic [1:0] push_sel;   // which byte to shift in
        logic       latch_len;  // capture the message bit length
        logic       init;       // load the working variables from the chain
        logic       round;      // perform one compression round
        logic [1:0] phase;      // round group, selects f and k
        logic       add;        // fold the working variables into the chain
        logic       finish;     // hand the digest to the output stage, reinit
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] fill;
        logic       out_busy;
    } t_dp_sts;

    localparam logic [31:0] H_INIT0 = 32'h6745_2301;
    localparam logic [31:0] H_INIT1 = 32'hefcd_ab89;
    localparam logic [31:0] H_INIT2 = 32'h98ba_dcfe;
    localparam logic [31:0] H_INIT3 = 32'h1032_5476;
    localparam logic [31:0] H_INIT4 = 32'hc3d2_e1f0;

    localparam logic [31:0] K_ROUND0 = 32'h5A82_7999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1B_BCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62_C1D6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [2:0] WORD_LAST  = 3'd4;

endpackage

// ===== rtl/sha1s_ifs.sv =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher channel interfaces
// Valid/ready channels for the byte input and the digest-word output.
// ----------------------------------------------------------------------------
interface sha1s_in_if;
    import sha1s_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface sha1s_out_if;
    import sha1s_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/sha1s_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher controller
// Sequences byte intake, padding, the 80 compression rounds and digest hand-off.
// ----------------------------------------------------------------------------
module sha1s_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  sha1s_pkg::t_in_item i_item,
    output logic                o_in_ready,
    input  sha1s_pkg::t_dp_sts  i_sts,
    output sha1s_pkg::t_dp_cmd  o_cmd
);
    import sha1s_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COMP = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_PADB = 3'd3;
    localparam logic [2:0] S_PADZ = 3'd4;
    localparam logic [2:0] S_PADL = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_ret, n_ret;
    logic [6:0] r_round, n_round;
    logic       w_full;

    assign w_full = (i_sts.fill == FILL_LAST);

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        n_ret      = r_ret;
        n_round    = r_round;
        if (r_round < 7'd20) begin
            o_cmd.phase = 2'd0;
        end else if (r_round < 7'd40) begin
            o_cmd.phase = 2'd1;
        end else if (r_round < 7'd60) begin
            o_cmd.phase = 2'd2;
        end else begin
            o_cmd.phase = 2'd3;
        end
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_item.has_byte) begin
                        o_cmd.push     = 1'b1;
                        o_cmd.push_sel = PUSH_DATA;
                    end
                    if (i_item.has_byte && w_full) begin
                        o_cmd.init = 1'b1;
                        n_round    = '0;
                        n_state    = S_COMP;
                        n_ret      = i_item.end_of_message ? S_PADB : S_IDLE;
                    end else if (i_item.end_of_message) begin
                        n_state = S_PADB;
                    end
                end
            end
            S_COMP: begin
                o_cmd.round = 1'b1;
                if (r_round == ROUND_LAST) begin
                    n_state = S_ADD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = r_ret;
            end
            S_PADB: begin
                o_cmd.push      = 1'b1;
                o_cmd.push_sel  = PUSH_PAD;
                o_cmd.latch_len = 1'b1;
                n_state         = S_PADZ;
                if (w_full) begin
                    o_cmd.init = 1'b1;
                    n_round    = '0;
                    n_state    = S_COMP;
                    n_ret      = S_PADZ;
                end
            end
            S_PADZ: begin
                if (i_sts.fill == LEN_POS) begin
                    n_state = S_PADL;
                end else begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_sel = PUSH_ZERO;
                    if (w_full) begin
                        o_cmd.init = 1'b1;
                        n_round    = '0;
                        n_state    = S_COMP;
                        n_ret      = S_PADZ;
                    end
                end
            end
            S_PADL: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_LEN;
                if (w_full) begin
                    o_cmd.init = 1'b1;
                    n_round    = '0;
                    n_state    = S_COMP;
                    n_ret      = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_round <= n_round;
        end
    end

endmodule

// ===== rtl/sha1s_dpath.sv =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher datapath
// Block window with message schedule, round logic, chain value, bit length
// and the digest output stage.
// ----------------------------------------------------------------------------
module sha1s_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_data_byte,
    input  sha1s_pkg::t_dp_cmd   i_cmd,
    output sha1s_pkg::t_dp_sts   o_sts,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sha1s_pkg::t_out_item o_out_item
);
    import sha1s_pkg::*;

    // The window holds sixteen schedule words, the oldest in the top word.
    logic [511:0] r_win;
    logic [5:0]   r_fill;
    logic [31:0]  r_blocks;
    logic [40:0]  r_len;
    logic [31:0]  r_chain [5];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [159:0] r_out_words;
    logic [2:0]   r_out_idx;
    logic         r_out_valid;

    logic [63:0]  w_len64;
    logic [7:0]   w_len_byte;
    logic [7:0]   w_push_byte;
    logic [31:0]  w_sched, w_new_word;
    logic [31:0]  w_f, w_k, w_t;

    assign w_len64    = {23'd0, r_len};
    assign w_len_byte = w_len64[{~r_fill[2:0], 3'b000} +: 8];

    always_comb begin
        unique case (i_cmd.push_sel)
            PUSH_DATA: w_push_byte = i_data_byte;
            PUSH_PAD:  w_push_byte = PAD_BYTE;
            PUSH_ZERO: w_push_byte = 8'd0;
            PUSH_LEN:  w_push_byte = w_len_byte;
            default:   w_push_byte = 8'd0;
        endcase
    end

    // Schedule word of this round and the word sixteen rounds ahead.
    assign w_sched = r_win[511:480];
    assign w_new_word = {w_sched[30:0], w_sched[31]} ^ {r_win[94:64], r_win[95]}
                      ^ {r_win[254:224], r_win[255]} ^ {r_win[446:416], r_win[447]};

    always_comb begin
        unique case (i_cmd.phase)
            2'd0: begin
                w_f = r_d ^ (r_b & (r_c ^ r_d));
                w_k = K_ROUND0;
            end
            2'd1: begin
                w_f = r_b ^ r_c ^ r_d;
                w_k = K_ROUND1;
            end
            2'd2: begin
                w_f = (r_b & r_c) | (r_d & (r_b | r_c));
                w_k = K_ROUND2;
            end
            default: begin
                w_f = r_b ^ r_c ^ r_d;
                w_k = K_ROUND3;
            end
        endcase
    end

    assign w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + w_sched;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_win <= {r_win[503:0], w_push_byte};
        end else if (i_cmd.round) begin
            r_win <= {r_win[479:0], w_new_word};
        end
        if (i_cmd.latch_len) begin
            r_len <= {r_blocks, r_fill, 3'b000};
        end
        if (i_cmd.init) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (i_cmd.round) begin
            r_a <= w_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
        if (i_cmd.finish) begin
            r_out_words <= {r_chain[0], r_chain[1], r_chain[2], r_chain[3], r_chain[4]};
        end else if (r_out_valid && i_out_ready) begin
            r_out_words <= {r_out_words[127:0], 32'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_blocks    <= '0;
            r_chain[0]  <= H_INIT0;
            r_chain[1]  <= H_INIT1;
            r_chain[2]  <= H_INIT2;
            r_chain[3]  <= H_INIT3;
            r_chain[4]  <= H_INIT4;
            r_out_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_fill <= r_fill + 6'd1;
                if (i_cmd.push_sel == PUSH_DATA && r_fill == FILL_LAST) begin
                    r_blocks <= r_blocks + 32'd1;
                end
            end
            if (i_cmd.add) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
                r_chain[4] <= r_chain[4] + r_e;
            end
            if (i_cmd.finish) begin
                r_fill      <= '0;
                r_blocks    <= '0;
                r_chain[0]  <= H_INIT0;
                r_chain[1]  <= H_INIT1;
                r_chain[2]  <= H_INIT2;
                r_chain[3]  <= H_INIT3;
                r_chain[4]  <= H_INIT4;
                r_out_idx   <= '0;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_idx <= r_out_idx + 3'd1;
                if (r_out_idx == WORD_LAST) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_sts.fill     = r_fill;
    assign o_sts.out_busy = r_out_valid;

    assign o_out_valid            = r_out_valid;
    assign o_out_item.digest_word = r_out_words[159:128];
    assign o_out_item.word_index  = r_out_idx;
    assign o_out_item.last_word   = (r_out_idx == WORD_LAST);

endmodule

// ===== rtl/sha1_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Hashes a byte stream and returns the 160-bit digest as five 32-bit words.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one request per message byte. A request with
// end_of_message set closes the message after its byte, if it carries one; a
// request with has_byte low and end_of_message set closes it with no byte, so
// the empty message is allowed. A request with neither flag does nothing.
// The output channel returns five requests per message, H0 first, each word in
// big-endian byte order, the fifth marked with last_word.
// Timing: a byte is taken whenever the controller is idle. The byte that fills
// a 64-byte block starts the compression, which runs one round per cycle
// through a single round unit: the 80 rounds, then the chain update. No new
// byte is taken until that block has been compressed.
// Closing a message feeds the pad, zero and length bytes and compresses one or
// two blocks, two when the closing byte fills a block or when the length no
// longer fits behind the pad byte in its block.
// The digest sits in its own output register, so the next message may stream
// in while a stalled receiver has not yet taken all five words; a second
// digest waits in the chain value until the register is free.
// Reset (synchronous, active low) restores the SHA-1 initial chain value,
// clears the byte and block counts and drops any pending output.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha1s_in_if.sink     i_in,
    sha1s_out_if.source  o_out
);
    import sha1s_pkg::*;

    t_dp_cmd   w_cmd;
    t_dp_sts   w_sts;
    t_in_item  w_item;
    t_out_item w_out_item;
    logic      w_in_ready;
    logic      w_out_valid;

    assign w_item     = i_in.data;
    assign i_in.ready = w_in_ready;

    // The controller only issues commands; all data storage lives in the datapath.
    sha1s_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_item     (w_item),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sha1s_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (w_item.data_byte),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (w_out_item)
    );

    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_item;

endmodule

// ===== rtl/sha1s_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher checker
// Port-level assertions on the digest output sequence, bound to the top level.
// ----------------------------------------------------------------------------
module sha1s_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word,
    input logic [2:0]  i_out_index,
    input logic        i_out_last
);
    import sha1s_pkg::*;

    // A digest always starts at word zero.
    a_start_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> (i_out_index == 3'd0))
        else $error("digest did not start at word zero");

    // The last flag marks exactly the fifth word.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_index == WORD_LAST)))
        else $error("last_word does not match word_index");

    // After a non-final word is taken the next word follows at once.
    a_next_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=>
        (i_out_valid && i_out_index == $past(i_out_index) + 3'd1))
        else $error("digest words not in sequence");

    // Taking the last word leaves the output register empty in the following cycle.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> !i_out_valid)
        else $error("output still valid after the last word");

    // A stalled word holds its value.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_word)))
        else $error("stalled digest word changed");

endmodule

bind sha1_stream_hasher sha1s_checker u_sha1s_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.data.digest_word),
    .i_out_index (o_out.data.word_index),
    .i_out_last  (o_out.data.last_word)
);
